@@ rtl/bomatch_pkg.sv @@
// Shared types and constants for the box overlap match scorer.
// No dependencies.
`timescale 1ns / 1ps

package bomatch_pkg;

    localparam int unsigned COORD_W     = 12;
    localparam int unsigned AREA_W      = 2 * COORD_W;   // intersection or one area
    localparam int unsigned UNION_W     = AREA_W + 1;
    localparam int unsigned Q16_W       = 17;            // 0 .. 65536
    localparam int unsigned SUM_W       = 40;
    localparam int unsigned BOX_W       = 4 * COORD_W;
    localparam int unsigned MAX_TRUTH_BOXES = 64;

    localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(65536);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_SCORE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } box_t;

endpackage

@@ rtl/bomatch_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bomatch_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bomatch_iou.sv @@
// Overlap pipeline: one stored box per cycle, keeps the best intersection/union
// pair by cross-multiplied comparison. Depends on bomatch_pkg.
`timescale 1ns / 1ps

module bomatch_iou (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  bomatch_pkg::box_t                 det,
    input  logic                              rd_valid,
    input  bomatch_pkg::box_t                 truth,
    output logic                              busy,
    output logic [bomatch_pkg::AREA_W-1:0]    best_inter,
    output logic [bomatch_pkg::UNION_W-1:0]   best_union
);
    localparam int unsigned CW = bomatch_pkg::COORD_W;
    localparam int unsigned AW = bomatch_pkg::AREA_W;
    localparam int unsigned UW = bomatch_pkg::UNION_W;

    logic          v1_reg, v2_reg, v3_reg;
    logic [CW-1:0] ix_reg, iy_reg, gw_reg, gh_reg;
    logic [AW-1:0] inter2_reg, garea_reg, darea_reg;
    logic [AW-1:0] inter3_reg;
    logic [UW-1:0] union3_reg;
    logic [AW-1:0] best_inter_reg;
    logic [UW-1:0] best_union_reg;

    logic [CW:0]   x_lo, x_hi, y_lo, y_hi, de_x, ge_x, de_y, ge_y;
    logic [CW-1:0] ix, iy;
    logic [AW+UW-1:0] lhs, rhs;

    always_comb
    begin
        x_lo = (det.x > truth.x) ? {1'b0, det.x} : {1'b0, truth.x};
        y_lo = (det.y > truth.y) ? {1'b0, det.y} : {1'b0, truth.y};
        de_x = {1'b0, det.x} + {1'b0, det.w};
        ge_x = {1'b0, truth.x} + {1'b0, truth.w};
        de_y = {1'b0, det.y} + {1'b0, det.h};
        ge_y = {1'b0, truth.y} + {1'b0, truth.h};
        x_hi = (de_x < ge_x) ? de_x : ge_x;
        y_hi = (de_y < ge_y) ? de_y : ge_y;
        // overlap never exceeds the shorter side, so it fits the coordinate width
        ix   = (x_hi > x_lo) ? CW'(x_hi - x_lo) : '0;
        iy   = (y_hi > y_lo) ? CW'(y_hi - y_lo) : '0;
    end

    // candidate beats best when inter/union > best_inter/best_union
    assign lhs = inter3_reg * best_union_reg;
    assign rhs = best_inter_reg * union3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            best_inter_reg <= '0;
            best_union_reg <= UW'(1);
        end
        else
        begin
            v1_reg <= rd_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (clear)
            begin
                best_inter_reg <= '0;
                best_union_reg <= UW'(1);
            end
            else if (v3_reg && (lhs > rhs))
            begin
                best_inter_reg <= inter3_reg;
                best_union_reg <= union3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ix_reg     <= ix;
        iy_reg     <= iy;
        gw_reg     <= truth.w;
        gh_reg     <= truth.h;
        inter2_reg <= ix_reg * iy_reg;
        garea_reg  <= gw_reg * gh_reg;
        darea_reg  <= det.w * det.h;
        inter3_reg <= inter2_reg;
        union3_reg <= {1'b0, darea_reg} + {1'b0, garea_reg} - {1'b0, inter2_reg};
    end

    assign busy       = rd_valid | v1_reg | v2_reg | v3_reg;
    assign best_inter = best_inter_reg;
    assign best_union = best_union_reg;

endmodule

@@ rtl/bomatch_div.sv @@
// Restoring divider: floor(inter * 65536 / union), one quotient bit a cycle.
// Depends on bomatch_pkg.
`timescale 1ns / 1ps

module bomatch_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bomatch_pkg::AREA_W-1:0]    inter,
    input  logic [bomatch_pkg::UNION_W-1:0]   uni,
    output logic                              done,
    output logic [bomatch_pkg::Q16_W-1:0]     quotient
);
    localparam int unsigned QW = bomatch_pkg::Q16_W;
    localparam int unsigned RW = bomatch_pkg::UNION_W + QW - 1;
    localparam int unsigned SW = $clog2(QW + 1);

    logic [RW-1:0] rem_reg, dv_reg;
    logic [QW-1:0] q_reg;
    logic [SW-1:0] step_reg;
    logic          done_reg;
    logic          ge;

    assign ge = (rem_reg >= dv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= SW'(QW);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - SW'(1);
                done_reg <= (step_reg == SW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, inter, {(QW-1){1'b0}}};
            dv_reg  <= {uni, {(QW-1){1'b0}}};
            q_reg   <= '0;
        end
        else if (step_reg != '0)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dv_reg;
            end
            q_reg  <= {q_reg[QW-2:0], ge};
            dv_reg <= dv_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/box_overlap_match_scorer_core.sv @@
// Box overlap match scorer: IoU of each detection against a frame's truth boxes.
// Start and add words leave the core idle and ready; a score word walks the stored
// boxes one per cycle from the RAM, then the 17-step divider; an empty table skips both.
// One word at a time; a finished result may wait in the output register.
// Reset: table empty, sums zero; RAM contents left undefined.
`timescale 1ns / 1ps

module box_overlap_match_scorer_core #(
    parameter int unsigned MAX_TRUTH_BOXES = bomatch_pkg::MAX_TRUTH_BOXES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          action,
    input  logic [bomatch_pkg::COORD_W-1:0]     box_x,
    input  logic [bomatch_pkg::COORD_W-1:0]     box_y,
    input  logic [bomatch_pkg::COORD_W-1:0]     box_width,
    input  logic [bomatch_pkg::COORD_W-1:0]     box_height,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bomatch_pkg::Q16_W-1:0]       best_overlap,
    output logic                                was_scored,
    output logic [bomatch_pkg::SUM_W-1:0]       true_positive_sum,
    output logic [bomatch_pkg::SUM_W-1:0]       false_sum
);
    localparam int unsigned AW = (MAX_TRUTH_BOXES > 1) ? $clog2(MAX_TRUTH_BOXES) : 1;
    localparam int unsigned CW = $clog2(MAX_TRUTH_BOXES + 1);
    localparam int unsigned QW = bomatch_pkg::Q16_W;
    localparam int unsigned SW = bomatch_pkg::SUM_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              issue_reg, issue_next;
    logic              scored_reg, scored_next;
    logic              was_scored_reg, was_scored_next;
    bomatch_pkg::box_t det_reg;
    logic [SW-1:0]     tp_reg, tp_next, miss_reg, miss_next;
    logic              out_valid_reg, out_valid_next;
    logic [QW-1:0]     best_reg, best_next;

    bomatch_pkg::box_t in_box, truth_box;
    logic              accept, ram_we, iou_busy, div_start, div_done, clear;
    logic [QW-1:0]     quotient, miss_add, best_pick;
    logic [SW:0]       tp_sum, miss_sum;
    logic [bomatch_pkg::AREA_W-1:0]  best_inter;
    logic [bomatch_pkg::UNION_W-1:0] best_union;
    logic [bomatch_pkg::BOX_W-1:0]   rd_word;

    assign in_box   = '{h: box_height, w: box_width, y: box_y, x: box_x};
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign ram_we   = accept && (action == bomatch_pkg::ACT_ADD) &&
                      (count_reg < CW'(MAX_TRUTH_BOXES));
    assign clear    = accept && (action == bomatch_pkg::ACT_SCORE);
    assign truth_box = bomatch_pkg::box_t'(rd_word);

    bomatch_ram #(
        .WIDTH (bomatch_pkg::BOX_W),
        .DEPTH (MAX_TRUTH_BOXES)
    ) u_truth_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_box),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_word)
    );

    bomatch_iou u_iou (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .det        (det_reg),
        .rd_valid   (issue_reg),
        .truth      (truth_box),
        .busy       (iou_busy),
        .best_inter (best_inter),
        .best_union (best_union)
    );

    bomatch_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .inter    (best_inter),
        .uni      (best_union),
        .done     (div_done),
        .quotient (quotient)
    );

    // divider output holds until the next start, so it is read straight in S_DONE
    assign best_pick = scored_reg ? quotient : '0;
    assign miss_add  = bomatch_pkg::Q16_ONE - best_pick;
    assign tp_sum    = {1'b0, tp_reg} + (SW+1)'(best_pick);
    assign miss_sum  = {1'b0, miss_reg} + (SW+1)'(miss_add);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        issue_next      = 1'b0;
        scored_next     = scored_reg;
        was_scored_next = was_scored_reg;
        tp_next         = tp_reg;
        miss_next       = miss_reg;
        out_valid_next  = out_valid_reg;
        best_next       = best_reg;
        div_start       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        bomatch_pkg::ACT_START: count_next = '0;
                        bomatch_pkg::ACT_ADD:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bomatch_pkg::ACT_SCORE:
                        begin
                            idx_next    = '0;
                            scored_next = (count_reg != '0);
                            state_next  = (count_reg != '0) ? S_WALK : S_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK:
            begin
                if (idx_reg != count_reg)
                begin
                    issue_next = 1'b1;
                    idx_next   = idx_reg + CW'(1);
                end
                else if (!issue_reg && !iou_busy)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    best_next       = best_pick;
                    was_scored_next = scored_reg;
                    if (scored_reg)
                    begin
                        tp_next   = tp_sum[SW] ? bomatch_pkg::SUM_MAX : tp_sum[SW-1:0];
                        miss_next = miss_sum[SW] ? bomatch_pkg::SUM_MAX : miss_sum[SW-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            issue_reg      <= 1'b0;
            scored_reg     <= 1'b0;
            was_scored_reg <= 1'b0;
            tp_reg         <= '0;
            miss_reg       <= '0;
            out_valid_reg  <= 1'b0;
            best_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            issue_reg      <= issue_next;
            scored_reg     <= scored_next;
            was_scored_reg <= was_scored_next;
            tp_reg         <= tp_next;
            miss_reg       <= miss_next;
            out_valid_reg  <= out_valid_next;
            best_reg       <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            det_reg <= in_box;
        end
    end

    assign out_valid         = out_valid_reg;
    assign best_overlap      = best_reg;
    assign was_scored        = was_scored_reg;
    assign true_positive_sum = tp_reg;
    assign false_sum         = miss_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TRUTH_BOXES))
        else $error("truth count above table depth");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> best_reg <= bomatch_pkg::Q16_ONE)
        else $error("overlap above one");

    a_unscored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !was_scored_reg) |-> best_reg == '0)
        else $error("unscored word with nonzero overlap");

endmodule

@@ bench/box_overlap_match_scorer_core_tb.sv @@
// Testbench for box_overlap_match_scorer_core: directed table then random frames.
// Depends on bomatch_pkg and the core; results checked against an IoU predictor.
`timescale 1ns / 1ps

module box_overlap_match_scorer_core_tb;
    localparam int unsigned COORD_W         = bomatch_pkg::COORD_W;
    localparam int unsigned Q16_W           = bomatch_pkg::Q16_W;
    localparam int unsigned SUM_W           = bomatch_pkg::SUM_W;
    localparam int unsigned MAX_TRUTH_BOXES = bomatch_pkg::MAX_TRUTH_BOXES;
    localparam logic [SUM_W-1:0] SUM_MAX    = bomatch_pkg::SUM_MAX;

    typedef struct {
        logic [Q16_W-1:0] best;
        logic             scored;
        logic [SUM_W-1:0] tp;
        logic [SUM_W-1:0] fs;
    } score_t;

    typedef struct {
        bomatch_pkg::action_t act;
        bomatch_pkg::box_t    b;
        bit                   typed;   // expectation typed in below
        score_t               want;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = bomatch_pkg::ACT_START;
    logic [COORD_W-1:0] box_x = '0, box_y = '0, box_width = '0, box_height = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [Q16_W-1:0] best_overlap;
    logic was_scored;
    logic [SUM_W-1:0] true_positive_sum, false_sum;

    // predictor state
    bomatch_pkg::box_t truth_tab [MAX_TRUTH_BOXES];
    int unsigned       truth_n = 0;
    logic [SUM_W-1:0]  pos_total = '0, miss_total = '0;
    score_t            pending_scores [$];

    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_rx = 1'b0;
    bit  long_hold_req = 1'b0;

    always #6 clk = ~clk;

    box_overlap_match_scorer_core i_dut (.*);

    function automatic longint unsigned span(longint unsigned a0, longint unsigned al,
                                             longint unsigned b0, longint unsigned bl);
        longint unsigned lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic logic [Q16_W-1:0] iou(bomatch_pkg::box_t d, bomatch_pkg::box_t g);
        longint unsigned inter, uni;
        inter = span(d.x, d.w, g.x, g.w) * span(d.y, d.h, g.y, g.h);
        uni = longint'(d.w) * d.h + longint'(g.w) * g.h - inter;
        if (uni == 0) return '0;
        return Q16_W'((inter * 65536) / uni);
    endfunction

    function automatic logic [SUM_W-1:0] sat40(logic [SUM_W-1:0] a, longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > longint'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
    endfunction

    // advance predictor by one accepted word; returns 1 with a score when one is due
    function automatic bit predict_word(bomatch_pkg::action_t a, bomatch_pkg::box_t b,
                                        output score_t r);
        logic [Q16_W-1:0] best, v;
        best = '0;
        r = '{default: '0};
        case (a)
            bomatch_pkg::ACT_START: truth_n = 0;
            bomatch_pkg::ACT_ADD:
                if (truth_n < MAX_TRUTH_BOXES)
                begin
                    truth_tab[truth_n] = b;
                    truth_n++;
                end
            bomatch_pkg::ACT_SCORE:
            begin
                for (int i = 0; i < truth_n; i++)
                begin
                    v = iou(b, truth_tab[i]);
                    if (v > best) best = v;
                end
                if (truth_n != 0)
                begin
                    pos_total = sat40(pos_total, best);
                    miss_total = sat40(miss_total, 65536 - longint'(best));
                    r.scored = 1'b1;
                    r.best = best;
                end
                r.tp = pos_total;
                r.fs = miss_total;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // valid stays up after acceptance; a gap or a drain drops it
    task automatic send_word(bomatch_pkg::action_t a, bomatch_pkg::box_t b);
        score_t r;
        action <= a; box_x <= b.x; box_y <= b.y; box_width <= b.w; box_height <= b.h;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (predict_word(a, b, r)) pending_scores.insert(pending_scores.size(), r);
    endtask

    task automatic gap_tx();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_tx();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_scores.size() != 0);
    endtask

    function automatic bomatch_pkg::box_t rand_box(int maxw);
        bomatch_pkg::box_t b;
        b.x = COORD_W'($urandom_range(0, 4095));
        b.y = COORD_W'($urandom_range(0, 4095));
        b.w = COORD_W'($urandom_range(0, maxw));
        b.h = COORD_W'($urandom_range(0, maxw));
        return b;
    endfunction

    function automatic bomatch_pkg::box_t near_box(bomatch_pkg::box_t g);
        bomatch_pkg::box_t b;
        b = g;
        b.x = COORD_W'(g.x + $urandom_range(0, 40) - 20);
        b.y = COORD_W'(g.y + $urandom_range(0, 40) - 20);
        b.w = COORD_W'(g.w + $urandom_range(0, 16) - 8);
        b.h = COORD_W'(g.h + $urandom_range(0, 16) - 8);
        return b;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        score_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t: unexpected result best=%0d", $time, best_overlap);
                errors++;
            end
            else
            begin
                e = pending_scores.pop_front();
                if (best_overlap !== e.best || was_scored !== e.scored ||
                    true_positive_sum !== e.tp || false_sum !== e.fs)
                begin
                    $display("%0t: mismatch exp best=%0d sc=%0d tp=%0d fs=%0d", $time,
                             e.best, e.scored, e.tp, e.fs);
                    $display("%0t:          got best=%0d sc=%0d tp=%0d fs=%0d", $time,
                             best_overlap, was_scored, true_positive_sum, false_sum);
                    errors++;
                end
            end
        end
        if (hold_rx)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        int cnt;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_rx = 1'b1;
                cnt = 0;
                while (cnt < 2000)
                begin
                    @(posedge clk);
                    cnt++;
                end
                hold_rx = 1'b0;
                long_hold_req = 1'b0;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                hold_rx = 1'b1;
                repeat ($urandom_range(20, 150)) @(posedge clk);
                hold_rx = 1'b0;
            end
        end
    end

    // watchdog on cycles without any acceptance
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        stim_t dir [16];
        score_t r;
        bomatch_pkg::box_t b, g;
        int total;
        bomatch_pkg::box_t zb, fb;
        zb = '{default: '0};
        fb = '{h: 12'hFFF, w: 12'hFFF, y: 12'hFFF, x: 12'hFFF};
        // directed rows: typed expectations where obvious
        dir[0]  = '{bomatch_pkg::ACT_SCORE, zb, 1, '{0, 0, 0, 0}};  // empty table after reset
        dir[1]  = '{bomatch_pkg::ACT_NONE, fb, 0, '{default: 0}};   // unused code ignored
        dir[2]  = '{bomatch_pkg::ACT_ADD, fb, 0, '{default: 0}};
        dir[3]  = '{bomatch_pkg::ACT_SCORE, fb, 1, '{65536, 1, 65536, 0}};  // identical full box
        dir[4]  = '{bomatch_pkg::ACT_SCORE, zb, 1, '{0, 1, 65536, 65536}};  // zero-size box
        dir[5]  = '{bomatch_pkg::ACT_START, fb, 0, '{default: 0}};
        dir[6]  = '{bomatch_pkg::ACT_ADD, zb, 0, '{default: 0}};
        dir[7]  = '{bomatch_pkg::ACT_SCORE, zb, 1, '{0, 1, 65536, 131072}};  // zero union
        dir[8]  = '{bomatch_pkg::ACT_ADD, '{h: 12'd10, w: 12'd10, y: 12'd0, x: 12'd0}, 0,
                    '{default: 0}};
        dir[9]  = '{bomatch_pkg::ACT_SCORE, '{h: 12'd10, w: 12'd5, y: 12'd0, x: 12'd5}, 0,
                    '{default: 0}};
        dir[10] = '{bomatch_pkg::ACT_SCORE, '{h: 12'd10, w: 12'd10, y: 12'd0, x: 12'd10}, 0,
                    '{default: 0}};                                 // touching edges
        dir[11] = '{bomatch_pkg::ACT_ADD, '{h: 12'd10, w: 12'd5, y: 12'd0, x: 12'd5}, 0,
                    '{default: 0}};
        dir[12] = '{bomatch_pkg::ACT_SCORE, '{h: 12'd10, w: 12'd5, y: 12'd0, x: 12'd5}, 0,
                    '{default: 0}};
        dir[13] = '{bomatch_pkg::ACT_SCORE, '{h: 12'd3, w: 12'd7, y: 12'd2, x: 12'd1}, 0,
                    '{default: 0}};
        dir[14] = '{bomatch_pkg::ACT_START, zb, 0, '{default: 0}};
        dir[15] = '{bomatch_pkg::ACT_SCORE, fb, 1, '{0, 0, 177602, 281150}};  // cleared table

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
        begin
            if (dir[i].typed)
                pending_scores.insert(pending_scores.size(), dir[i].want);
            send_word(dir[i].act, dir[i].b);
            if (dir[i].typed)
            begin
                // the predictor also queued one; drop it, keep the typed row
                r = pending_scores.pop_back();
            end
            gap_tx();
        end

        // full table, then overflow of the table
        send_word(bomatch_pkg::ACT_START, zb);
        for (int i = 0; i < MAX_TRUTH_BOXES + 3; i++)
            send_word(bomatch_pkg::ACT_ADD, rand_box(300));
        // fill the output path while the receiver holds off
        long_hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_word(bomatch_pkg::ACT_SCORE,
                      truth_tab[$urandom_range(0, MAX_TRUTH_BOXES - 1)]);
        in_valid <= 1'b0;
        @(posedge clk);
        while (long_hold_req) @(posedge clk);

        // random frames
        total = 0;
        while (total < 1850)
        begin
            int nt;
            send_word(bomatch_pkg::ACT_START, rand_box(4095));
            total++;
            nt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 6);
            for (int i = 0; i < nt; i++)
            begin
                g = ($urandom_range(0, 9) == 0) ? rand_box(4095) : rand_box(400);
                send_word(bomatch_pkg::ACT_ADD, g);
                total++;
                gap_tx();
            end
            for (int i = 0; i < $urandom_range(1, 5); i++)
            begin
                if (truth_n != 0 && $urandom_range(0, 3) != 0)
                    b = near_box(truth_tab[$urandom_range(0, truth_n - 1)]);
                else
                    b = rand_box(($urandom_range(0, 4) == 0) ? 4095 : 400);
                send_word(bomatch_pkg::action_t'(($urandom_range(0, 19) == 0) ?
                          bomatch_pkg::ACT_NONE : bomatch_pkg::ACT_SCORE), b);
                total++;
                gap_tx();
            end
            if ($urandom_range(0, 39) == 0)
                drain_tx();
        end

        drain_tx();
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_scores.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bomatch_pkg.sv
rtl/bomatch_ram.sv
rtl/bomatch_iou.sv
rtl/bomatch_div.sv
rtl/box_overlap_match_scorer_core.sv
bench/box_overlap_match_scorer_core_tb.sv
